/* rtl/ils_pkg.sv */
`default_nettype none

package ils_pkg;

	localparam int CNT_W     = 32;
	localparam int SUM_W     = 48;
	localparam int LAT_W     = 32;
	localparam int AVG_W     = 40;
	localparam int FRAC_W    = 8;
	localparam int DIVD_W    = SUM_W + FRAC_W;
	localparam int STEP_W    = 6;
	localparam int DIV_STEPS = DIVD_W;

	localparam logic [1:0] FUNC_RECORD = 2'd0;
	localparam logic [1:0] FUNC_READ   = 2'd1;
	localparam logic [1:0] FUNC_TOTALS = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
		logic [LAT_W-1:0] worst;
	} line_stats_t;

endpackage

`default_nettype wire

/* rtl/irq_latency_statistics_core.sv */
`default_nettype none

// Interrupt latency statistics. Each transaction (start high while busy is
// low) carries func, line and latency: a record updates the line's count,
// sum and worst latency together with the totals over all lines, a read
// returns one line, a totals request returns the totals. Every transaction
// gives exactly one result, shown for one cycle with strobe high; the
// receiver cannot stall, so it must take the result in that cycle. strobe
// rises after the statistics memory read, the update and the bit-serial
// restoring divider that forms the average (sum * 256 / count, one quotient
// bit per cycle). busy is low again in the strobe cycle, so the next
// transaction may be accepted at the edge that ends it. There is no clearing
// pass: per-line valid flags make untouched entries read as zero.
module irq_latency_statistics_core #(
	parameter int LINES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [3:0]  line,
	input  wire logic [31:0] latency,
	output logic             strobe,
	output logic             seen,
	output logic [31:0]      event_count,
	output logic [47:0]      latency_sum,
	output logic [39:0]      mean_latency,
	output logic [31:0]      peak_latency
);

	localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
	localparam logic [6:0] LINES_LIM = 7'(LINES);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	logic [1:0] state_q;

	// latched transaction
	logic [1:0]                  func_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        ok_q;
	logic [ils_pkg::LAT_W-1:0]   lat_q;

	// statistics store: one word per line, valid flags in flops
	ils_pkg::line_stats_t        mem_q [LINES];
	ils_pkg::line_stats_t        rd_q;
	logic [LINES-1:0]            valid_q;

	// totals over all lines
	logic [ils_pkg::CNT_W-1:0]   tot_count_q;
	logic [ils_pkg::SUM_W-1:0]   tot_sum_q;
	logic [ils_pkg::LAT_W-1:0]   tot_worst_q;

	// result registers
	logic                        strobe_q;
	logic                        seen_q;
	logic [ils_pkg::CNT_W-1:0]   count_q;
	logic [ils_pkg::SUM_W-1:0]   sum_q;
	logic [ils_pkg::AVG_W-1:0]   avg_q;
	logic [ils_pkg::LAT_W-1:0]   worst_q;

	// divider
	logic [ils_pkg::CNT_W-1:0]   div_q;
	logic [ils_pkg::CNT_W-1:0]   rem_q;
	logic [ils_pkg::DIVD_W-1:0]  dq_q;
	logic [ils_pkg::STEP_W-1:0]  step_q;

	logic [6:0]                  line_ext;
	logic                        accept;
	logic                        rec;
	logic                        entry_valid;
	ils_pkg::line_stats_t        entry;
	ils_pkg::line_stats_t        entry_new;
	logic [ils_pkg::SUM_W:0]     line_sum_wide;
	logic [ils_pkg::SUM_W:0]     tot_sum_wide;
	logic [ils_pkg::CNT_W-1:0]   tot_count_new;
	logic [ils_pkg::SUM_W-1:0]   tot_sum_new;
	logic [ils_pkg::LAT_W-1:0]   tot_worst_new;

	logic                        res_seen;
	logic [ils_pkg::CNT_W-1:0]   res_count;
	logic [ils_pkg::SUM_W-1:0]   res_sum;
	logic [ils_pkg::LAT_W-1:0]   res_worst;

	logic [ils_pkg::CNT_W:0]     trial;
	logic [ils_pkg::CNT_W:0]     diff;
	logic                        ge;
	logic [ils_pkg::DIVD_W-1:0]  dq_next;
	logic [ils_pkg::AVG_W-1:0]   avg_final;

	assign line_ext = {3'b000, line};
	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);

	assign strobe       = strobe_q;
	assign seen         = seen_q;
	assign event_count  = count_q;
	assign latency_sum  = sum_q;
	assign mean_latency = avg_q;
	assign peak_latency = worst_q;

	// line update, never-written entries read as zero
	always_comb begin
		entry_valid = ok_q && valid_q[idx_q];
		entry       = entry_valid ? rd_q : '0;
		rec         = ok_q && (func_q == ils_pkg::FUNC_RECORD);

		entry_new.count = (&entry.count) ? entry.count : entry.count + 1'b1;
		line_sum_wide   = {1'b0, entry.sum} + {17'd0, lat_q};
		entry_new.sum   = line_sum_wide[ils_pkg::SUM_W] ? '1
			: line_sum_wide[ils_pkg::SUM_W-1:0];
		// an empty entry has worst zero, so strict compare still takes the first one
		entry_new.worst = (lat_q > entry.worst) ? lat_q : entry.worst;

		tot_count_new = (&tot_count_q) ? tot_count_q : tot_count_q + 1'b1;
		tot_sum_wide  = {1'b0, tot_sum_q} + {17'd0, lat_q};
		tot_sum_new   = tot_sum_wide[ils_pkg::SUM_W] ? '1
			: tot_sum_wide[ils_pkg::SUM_W-1:0];
		tot_worst_new = (lat_q > tot_worst_q) ? lat_q : tot_worst_q;

		res_seen  = 1'b0;
		res_count = '0;
		res_sum   = '0;
		res_worst = '0;
		case (func_q)
			ils_pkg::FUNC_TOTALS: begin
				res_seen  = (tot_count_q != '0);
				res_count = tot_count_q;
				res_sum   = tot_sum_q;
				res_worst = tot_worst_q;
			end
			ils_pkg::FUNC_RECORD: begin
				if (ok_q) begin
					res_seen  = 1'b1;
					res_count = entry_new.count;
					res_sum   = entry_new.sum;
					res_worst = entry_new.worst;
				end
			end
			ils_pkg::FUNC_READ: begin
				if (ok_q) begin
					res_seen  = entry_valid;
					res_count = entry.count;
					res_sum   = entry.sum;
					res_worst = entry.worst;
				end
			end
			default: begin
				res_seen = 1'b0;
			end
		endcase
	end

	// one restoring division step
	always_comb begin
		trial   = {rem_q, dq_q[ils_pkg::DIVD_W-1]};
		diff    = trial - {1'b0, div_q};
		ge      = (trial >= {1'b0, div_q});
		dq_next = {dq_q[ils_pkg::DIVD_W-2:0], ge};
		if (div_q == '0) begin
			avg_final = '0;
		end else if (|dq_next[ils_pkg::DIVD_W-1:ils_pkg::AVG_W]) begin
			avg_final = '1;
		end else begin
			avg_final = dq_next[ils_pkg::AVG_W-1:0];
		end
	end

	// statistics memory, no reset
	always_ff @(posedge clk) begin
		rd_q <= mem_q[idx_q];
		if (state_q == ST_UPD && rec) begin
			mem_q[idx_q] <= entry_new;
		end
	end

	// transaction latch and datapath payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			idx_q  <= line_ext[IDX_W-1:0];
			ok_q   <= (line_ext < LINES_LIM);
			lat_q  <= latency;
		end
		if (state_q == ST_UPD) begin
			seen_q  <= res_seen;
			count_q <= res_count;
			sum_q   <= res_sum;
			worst_q <= res_worst;
			div_q   <= res_count;
			rem_q   <= '0;
			dq_q    <= {res_sum, {ils_pkg::FRAC_W{1'b0}}};
		end
		if (state_q == ST_DIV) begin
			rem_q <= ge ? diff[ils_pkg::CNT_W-1:0] : trial[ils_pkg::CNT_W-1:0];
			dq_q  <= dq_next;
			if (step_q == ils_pkg::STEP_W'(1)) begin
				avg_q <= avg_final;
			end
		end
	end

	// sequencer, valid flags and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			strobe_q    <= 1'b0;
			step_q      <= '0;
			valid_q     <= '0;
			tot_count_q <= '0;
			tot_sum_q   <= '0;
			tot_worst_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (rec) begin
						valid_q[idx_q] <= 1'b1;
						tot_count_q    <= tot_count_new;
						tot_sum_q      <= tot_sum_new;
						tot_worst_q    <= tot_worst_new;
					end
					step_q  <= ils_pkg::STEP_W'(ils_pkg::DIV_STEPS);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == ils_pkg::STEP_W'(1)) begin
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
